// File: hw/rtl/hrf_pkg.sv
`default_nettype none

package hrf_pkg;

    localparam int NREG = 32;
    localparam int RA_W = 5;
    localparam int PC_W = 7;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

    localparam logic [1:0] RG_LEFT   = 2'd0;
    localparam logic [1:0] RG_LSTAR  = 2'd1;
    localparam logic [1:0] RG_RSTAR  = 2'd2;
    localparam logic [1:0] RG_RIGHT  = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_ZDEN = 2'd1;
    localparam logic [1:0] ST_NEGP = 2'd2;

    // Scratch register indexes. Inputs and constants double as load sources.
    localparam logic [RA_W-1:0] R_RL = 5'd0;
    localparam logic [RA_W-1:0] R_UL = 5'd1;
    localparam logic [RA_W-1:0] R_PL = 5'd2;
    localparam logic [RA_W-1:0] R_RR = 5'd3;
    localparam logic [RA_W-1:0] R_UR = 5'd4;
    localparam logic [RA_W-1:0] R_PR = 5'd5;
    localparam logic [RA_W-1:0] R_KG = 5'd6;
    localparam logic [RA_W-1:0] R_KS = 5'd7;
    localparam logic [RA_W-1:0] R_KI = 5'd8;
    localparam logic [RA_W-1:0] R_KH = 5'd9;
    localparam logic [RA_W-1:0] R_K1 = 5'd10;
    localparam logic [RA_W-1:0] R_AL = 5'd11;
    localparam logic [RA_W-1:0] R_AR = 5'd12;
    localparam logic [RA_W-1:0] R_PS = 5'd13;
    localparam logic [RA_W-1:0] R_SL = 5'd14;
    localparam logic [RA_W-1:0] R_SR = 5'd15;
    localparam logic [RA_W-1:0] R_DL = 5'd16;
    localparam logic [RA_W-1:0] R_DR = 5'd17;
    localparam logic [RA_W-1:0] R_SS = 5'd18;
    localparam logic [RA_W-1:0] R_XR = 5'd19;
    localparam logic [RA_W-1:0] R_XU = 5'd20;
    localparam logic [RA_W-1:0] R_XP = 5'd21;
    localparam logic [RA_W-1:0] R_XS = 5'd22;
    localparam logic [RA_W-1:0] R_E  = 5'd23;
    localparam logic [RA_W-1:0] R_M  = 5'd24;
    localparam logic [RA_W-1:0] R_F1 = 5'd25;
    localparam logic [RA_W-1:0] R_F2 = 5'd26;
    localparam logic [RA_W-1:0] R_T0 = 5'd27;
    localparam logic [RA_W-1:0] R_T1 = 5'd28;
    localparam logic [RA_W-1:0] R_T2 = 5'd29;
    localparam logic [RA_W-1:0] R_AB = R_DL;
    localparam logic [RA_W-1:0] R_RD = R_AL;
    localparam logic [RA_W-1:0] R_PF = R_AR;
    localparam logic [RA_W-1:0] R_NONE = 5'd0;

    localparam logic [PC_W-1:0] P_NONE = 7'd0;
    localparam logic [PC_W-1:0] P_R3   = 7'd65;
    localparam logic [PC_W-1:0] P_L0   = 7'd70;
    localparam logic [PC_W-1:0] P_L1   = 7'd75;
    localparam logic [PC_W-1:0] P_R2   = 7'd81;
    localparam logic [PC_W-1:0] P_FLUX = 7'd86;
    localparam logic [PC_W-1:0] P_OUT  = 7'd118;

    typedef enum logic [4:0] {
        OP_LD, OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_SQRT, OP_AVG, OP_ABS,
        OP_MAX0, OP_PICK, OP_SMAX, OP_ZCHK, OP_REG, OP_BGEZ, OP_JMP, OP_BNS,
        OP_OUTA, OP_OUTB
    } t_op;

    typedef struct packed {
        t_op             op;
        logic [RA_W-1:0] dst;
        logic [RA_W-1:0] a;
        logic [RA_W-1:0] b;
        logic [PC_W-1:0] tgt;
    } t_instr;

    typedef struct packed {
        logic signed [31:0] l_r;
        logic signed [31:0] l_u;
        logic signed [31:0] l_p;
        logic signed [31:0] r_r;
        logic signed [31:0] r_u;
        logic signed [31:0] r_p;
        logic               clr;
    } t_pair;

    function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
        logic signed [31:0] r;
        if (v[32] != v[31]) begin
            r = v[32] ? S32_MIN : S32_MAX;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

    function automatic logic signed [31:0] q_add(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return sat33(33'(a) + 33'(b));
    endfunction

    function automatic logic signed [31:0] q_sub(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        return sat33(33'(a) - 33'(b));
    endfunction

    function automatic logic signed [31:0] q_avg(input logic signed [31:0] a,
                                                 input logic signed [31:0] b);
        logic signed [32:0] s;
        s = 33'(a) + 33'(b);
        return s[32:1];
    endfunction

    function automatic logic signed [31:0] q_abs(input logic signed [31:0] a);
        logic signed [31:0] r;
        if (a == S32_MIN) begin
            r = S32_MAX;
        end else if (a[31]) begin
            r = -a;
        end else begin
            r = a;
        end
        return r;
    endfunction

    function automatic t_instr mk(input t_op o, input logic [RA_W-1:0] d,
                                  input logic [RA_W-1:0] a, input logic [RA_W-1:0] b,
                                  input logic [PC_W-1:0] t);
        t_instr i;
        i.op  = o;
        i.dst = d;
        i.a   = a;
        i.b   = b;
        i.tgt = t;
        return i;
    endfunction

    function automatic t_instr prog(input logic [PC_W-1:0] pc);
        t_instr i;
        unique case (pc)
            7'd0:   i = mk(OP_LD,   R_RL, R_RL, R_NONE, P_NONE);
            7'd1:   i = mk(OP_LD,   R_UL, R_UL, R_NONE, P_NONE);
            7'd2:   i = mk(OP_LD,   R_PL, R_PL, R_NONE, P_NONE);
            7'd3:   i = mk(OP_LD,   R_RR, R_RR, R_NONE, P_NONE);
            7'd4:   i = mk(OP_LD,   R_UR, R_UR, R_NONE, P_NONE);
            7'd5:   i = mk(OP_LD,   R_PR, R_PR, R_NONE, P_NONE);
            7'd6:   i = mk(OP_LD,   R_KG, R_KG, R_NONE, P_NONE);
            7'd7:   i = mk(OP_LD,   R_KS, R_KS, R_NONE, P_NONE);
            7'd8:   i = mk(OP_LD,   R_KI, R_KI, R_NONE, P_NONE);
            7'd9:   i = mk(OP_LD,   R_KH, R_KH, R_NONE, P_NONE);
            7'd10:  i = mk(OP_LD,   R_K1, R_K1, R_NONE, P_NONE);
            7'd11:  i = mk(OP_MUL,  R_T0, R_KG, R_PL, P_NONE);
            7'd12:  i = mk(OP_DIV,  R_T0, R_T0, R_RL, P_NONE);
            7'd13:  i = mk(OP_SQRT, R_AL, R_T0, R_NONE, P_NONE);
            7'd14:  i = mk(OP_MUL,  R_T0, R_KG, R_PR, P_NONE);
            7'd15:  i = mk(OP_DIV,  R_T0, R_T0, R_RR, P_NONE);
            7'd16:  i = mk(OP_SQRT, R_AR, R_T0, R_NONE, P_NONE);
            7'd17:  i = mk(OP_AVG,  R_T1, R_PL, R_PR, P_NONE);
            7'd18:  i = mk(OP_AVG,  R_T2, R_RL, R_RR, P_NONE);
            7'd19:  i = mk(OP_AVG,  R_AB, R_AL, R_AR, P_NONE);
            7'd20:  i = mk(OP_SUB,  R_T0, R_UR, R_UL, P_NONE);
            7'd21:  i = mk(OP_MUL,  R_T0, R_KH, R_T0, P_NONE);
            7'd22:  i = mk(OP_MUL,  R_T0, R_T0, R_AB, P_NONE);
            7'd23:  i = mk(OP_MUL,  R_T0, R_T0, R_T2, P_NONE);
            7'd24:  i = mk(OP_SUB,  R_PS, R_T1, R_T0, P_NONE);
            7'd25:  i = mk(OP_MAX0, R_PS, R_PS, R_NONE, P_NONE);
            7'd26:  i = mk(OP_DIV,  R_T0, R_PS, R_PL, P_NONE);
            7'd27:  i = mk(OP_SUB,  R_T0, R_T0, R_K1, P_NONE);
            7'd28:  i = mk(OP_MUL,  R_T0, R_KS, R_T0, P_NONE);
            7'd29:  i = mk(OP_ADD,  R_T0, R_K1, R_T0, P_NONE);
            7'd30:  i = mk(OP_SQRT, R_T0, R_T0, R_NONE, P_NONE);
            7'd31:  i = mk(OP_PICK, R_T0, R_PS, R_PL, P_NONE);
            7'd32:  i = mk(OP_MUL,  R_T0, R_AL, R_T0, P_NONE);
            7'd33:  i = mk(OP_SUB,  R_SL, R_UL, R_T0, P_NONE);
            7'd34:  i = mk(OP_DIV,  R_T0, R_PS, R_PR, P_NONE);
            7'd35:  i = mk(OP_SUB,  R_T0, R_T0, R_K1, P_NONE);
            7'd36:  i = mk(OP_MUL,  R_T0, R_KS, R_T0, P_NONE);
            7'd37:  i = mk(OP_ADD,  R_T0, R_K1, R_T0, P_NONE);
            7'd38:  i = mk(OP_SQRT, R_T0, R_T0, R_NONE, P_NONE);
            7'd39:  i = mk(OP_PICK, R_T0, R_PS, R_PR, P_NONE);
            7'd40:  i = mk(OP_MUL,  R_T0, R_AR, R_T0, P_NONE);
            7'd41:  i = mk(OP_ADD,  R_SR, R_UR, R_T0, P_NONE);
            7'd42:  i = mk(OP_ABS,  R_T0, R_UL, R_NONE, P_NONE);
            7'd43:  i = mk(OP_ADD,  R_T0, R_T0, R_AL, P_NONE);
            7'd44:  i = mk(OP_SMAX, R_NONE, R_T0, R_NONE, P_NONE);
            7'd45:  i = mk(OP_ABS,  R_T0, R_UR, R_NONE, P_NONE);
            7'd46:  i = mk(OP_ADD,  R_T0, R_T0, R_AR, P_NONE);
            7'd47:  i = mk(OP_SMAX, R_NONE, R_T0, R_NONE, P_NONE);
            7'd48:  i = mk(OP_SUB,  R_DL, R_SL, R_UL, P_NONE);
            7'd49:  i = mk(OP_SUB,  R_DR, R_SR, R_UR, P_NONE);
            7'd50:  i = mk(OP_SUB,  R_T0, R_PR, R_PL, P_NONE);
            7'd51:  i = mk(OP_MUL,  R_T1, R_RL, R_UL, P_NONE);
            7'd52:  i = mk(OP_MUL,  R_T1, R_T1, R_DL, P_NONE);
            7'd53:  i = mk(OP_ADD,  R_T0, R_T0, R_T1, P_NONE);
            7'd54:  i = mk(OP_MUL,  R_T1, R_RR, R_UR, P_NONE);
            7'd55:  i = mk(OP_MUL,  R_T1, R_T1, R_DR, P_NONE);
            7'd56:  i = mk(OP_SUB,  R_T0, R_T0, R_T1, P_NONE);
            7'd57:  i = mk(OP_MUL,  R_T1, R_RL, R_DL, P_NONE);
            7'd58:  i = mk(OP_MUL,  R_T2, R_RR, R_DR, P_NONE);
            7'd59:  i = mk(OP_SUB,  R_T1, R_T1, R_T2, P_NONE);
            7'd60:  i = mk(OP_ZCHK, R_NONE, R_T1, R_NONE, P_NONE);
            7'd61:  i = mk(OP_DIV,  R_SS, R_T0, R_T1, P_NONE);
            7'd62:  i = mk(OP_BGEZ, R_NONE, R_SL, R_NONE, P_L0);
            7'd63:  i = mk(OP_BGEZ, R_NONE, R_SS, R_NONE, P_L1);
            7'd64:  i = mk(OP_BGEZ, R_NONE, R_SR, R_NONE, P_R2);
            7'd65:  i = mk(OP_REG,  R_NONE, {3'b000, RG_RIGHT}, R_NONE, P_NONE);
            7'd66:  i = mk(OP_MOV,  R_XR, R_RR, R_NONE, P_NONE);
            7'd67:  i = mk(OP_MOV,  R_XU, R_UR, R_NONE, P_NONE);
            7'd68:  i = mk(OP_MOV,  R_XP, R_PR, R_NONE, P_NONE);
            7'd69:  i = mk(OP_JMP,  R_NONE, R_NONE, R_NONE, P_FLUX);
            7'd70:  i = mk(OP_REG,  R_NONE, {3'b000, RG_LEFT}, R_NONE, P_NONE);
            7'd71:  i = mk(OP_MOV,  R_XR, R_RL, R_NONE, P_NONE);
            7'd72:  i = mk(OP_MOV,  R_XU, R_UL, R_NONE, P_NONE);
            7'd73:  i = mk(OP_MOV,  R_XP, R_PL, R_NONE, P_NONE);
            7'd74:  i = mk(OP_JMP,  R_NONE, R_NONE, R_NONE, P_FLUX);
            7'd75:  i = mk(OP_REG,  R_NONE, {3'b000, RG_LSTAR}, R_NONE, P_NONE);
            7'd76:  i = mk(OP_MOV,  R_XR, R_RL, R_NONE, P_NONE);
            7'd77:  i = mk(OP_MOV,  R_XU, R_UL, R_NONE, P_NONE);
            7'd78:  i = mk(OP_MOV,  R_XP, R_PL, R_NONE, P_NONE);
            7'd79:  i = mk(OP_MOV,  R_XS, R_SL, R_NONE, P_NONE);
            7'd80:  i = mk(OP_JMP,  R_NONE, R_NONE, R_NONE, P_FLUX);
            7'd81:  i = mk(OP_REG,  R_NONE, {3'b000, RG_RSTAR}, R_NONE, P_NONE);
            7'd82:  i = mk(OP_MOV,  R_XR, R_RR, R_NONE, P_NONE);
            7'd83:  i = mk(OP_MOV,  R_XU, R_UR, R_NONE, P_NONE);
            7'd84:  i = mk(OP_MOV,  R_XP, R_PR, R_NONE, P_NONE);
            7'd85:  i = mk(OP_MOV,  R_XS, R_SR, R_NONE, P_NONE);
            7'd86:  i = mk(OP_MUL,  R_T0, R_XU, R_XU, P_NONE);
            7'd87:  i = mk(OP_MUL,  R_T0, R_XR, R_T0, P_NONE);
            7'd88:  i = mk(OP_MUL,  R_T0, R_KH, R_T0, P_NONE);
            7'd89:  i = mk(OP_MUL,  R_T1, R_KI, R_XP, P_NONE);
            7'd90:  i = mk(OP_ADD,  R_E,  R_T1, R_T0, P_NONE);
            7'd91:  i = mk(OP_MUL,  R_M,  R_XR, R_XU, P_NONE);
            7'd92:  i = mk(OP_MUL,  R_T0, R_M,  R_XU, P_NONE);
            7'd93:  i = mk(OP_ADD,  R_F1, R_T0, R_XP, P_NONE);
            7'd94:  i = mk(OP_ADD,  R_T0, R_E,  R_XP, P_NONE);
            7'd95:  i = mk(OP_MUL,  R_F2, R_XU, R_T0, P_NONE);
            7'd96:  i = mk(OP_BNS,  R_NONE, R_NONE, R_NONE, P_OUT);
            7'd97:  i = mk(OP_SUB,  R_T0, R_XS, R_XU, P_NONE);
            7'd98:  i = mk(OP_MUL,  R_RD, R_XR, R_T0, P_NONE);
            7'd99:  i = mk(OP_SUB,  R_T0, R_XS, R_SS, P_NONE);
            7'd100: i = mk(OP_DIV,  R_PF, R_RD, R_T0, P_NONE);
            7'd101: i = mk(OP_MUL,  R_T0, R_PF, R_SS, P_NONE);
            7'd102: i = mk(OP_SUB,  R_T0, R_T0, R_M, P_NONE);
            7'd103: i = mk(OP_MUL,  R_T0, R_XS, R_T0, P_NONE);
            7'd104: i = mk(OP_ADD,  R_F1, R_F1, R_T0, P_NONE);
            7'd105: i = mk(OP_SUB,  R_T0, R_PF, R_XR, P_NONE);
            7'd106: i = mk(OP_MUL,  R_T0, R_XS, R_T0, P_NONE);
            7'd107: i = mk(OP_ADD,  R_M,  R_M,  R_T0, P_NONE);
            7'd108: i = mk(OP_DIV,  R_T0, R_XP, R_RD, P_NONE);
            7'd109: i = mk(OP_ADD,  R_T0, R_SS, R_T0, P_NONE);
            7'd110: i = mk(OP_SUB,  R_T1, R_SS, R_XU, P_NONE);
            7'd111: i = mk(OP_MUL,  R_T0, R_T1, R_T0, P_NONE);
            7'd112: i = mk(OP_DIV,  R_T1, R_E,  R_XR, P_NONE);
            7'd113: i = mk(OP_ADD,  R_T0, R_T1, R_T0, P_NONE);
            7'd114: i = mk(OP_MUL,  R_T0, R_PF, R_T0, P_NONE);
            7'd115: i = mk(OP_SUB,  R_T0, R_T0, R_E, P_NONE);
            7'd116: i = mk(OP_MUL,  R_T0, R_XS, R_T0, P_NONE);
            7'd117: i = mk(OP_ADD,  R_F2, R_F2, R_T0, P_NONE);
            7'd118: i = mk(OP_OUTA, R_NONE, R_M, R_F1, P_NONE);
            default: i = mk(OP_OUTB, R_NONE, R_F2, R_NONE, P_NONE);
        endcase
        return i;
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/hrf_ram.sv
`default_nettype none

module hrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// File: hw/rtl/hrf_iter.sv
`default_nettype none

module hrf_iter #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_start,
    input  wire logic               i_sqrt,
    input  wire logic signed [31:0] i_a,
    input  wire logic signed [31:0] i_b,
    output logic                    o_done,
    output logic signed [31:0]      o_res
);
    import hrf_pkg::*;

    localparam int NW = 32 + FRAC_BITS;
    localparam int SQ = (NW + 1) / 2;
    localparam int SW = 2 * SQ;
    localparam int RW = (SQ + 2 > 33) ? SQ + 2 : 33;
    localparam int CW = $clog2(SW + 1);

    logic          r_busy;
    logic          r_sqrt;
    logic          r_neg;
    logic [CW-1:0] r_cnt;
    logic [SW-1:0] r_sh;
    logic [SW-1:0] r_q;
    logic [RW-1:0] r_rem;
    logic [31:0]   r_den;

    logic [31:0]   mag_a;
    logic [31:0]   mag_b;
    logic [NW-1:0] shifted;
    logic [RW-1:0] rem_d;
    logic [RW-1:0] rem_s;
    logic [RW-1:0] trial;
    logic          take;
    logic [RW-1:0] n_rem;

    assign mag_a   = i_a[31] ? 32'(-i_a) : 32'(i_a);
    assign mag_b   = i_b[31] ? 32'(-i_b) : 32'(i_b);
    assign shifted = {mag_a, {FRAC_BITS{1'b0}}};

    assign rem_d = {r_rem[RW-2:0], r_sh[SW-1]};
    assign rem_s = {r_rem[RW-3:0], r_sh[SW-1:SW-2]};
    assign trial = RW'({r_q[SQ-1:0], 2'b01});

    always_comb begin
        if (r_sqrt) begin
            take  = rem_s >= trial;
            n_rem = take ? rem_s - trial : rem_s;
        end else begin
            take  = rem_d >= RW'(r_den);
            n_rem = take ? rem_d - RW'(r_den) : rem_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CW'(1))) begin
                r_busy <= 1'b0;
            end
        end
        if (i_start) begin
            r_sqrt <= i_sqrt;
            r_neg  <= i_a[31] ^ i_b[31];
            r_den  <= mag_b;
            r_rem  <= '0;
            r_q    <= '0;
            r_cnt  <= i_sqrt ? CW'(SQ) : CW'(NW);
            r_sh   <= i_sqrt ? SW'(shifted) : SW'(shifted) << (SW - NW);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_q   <= {r_q[SW-2:0], take};
            r_cnt <= r_cnt - CW'(1);
            r_sh  <= r_sqrt ? {r_sh[SW-3:0], 2'b00} : {r_sh[SW-2:0], 1'b0};
        end
    end

    always_comb begin
        if (r_sqrt) begin
            o_res = r_q[31:0];
        end else if (r_neg) begin
            if ((r_q[SW-1:32] != '0) || (r_q[31] && (r_q[30:0] != '0))) begin
                o_res = S32_MIN;
            end else begin
                o_res = -$signed(r_q[31:0]);
            end
        end else if (r_q[SW-1:31] != '0) begin
            o_res = S32_MAX;
        end else begin
            o_res = r_q[31:0];
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/hrf_front.sv
`default_nettype none

module hrf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire logic [95:0]   i_data,
    input  wire logic          i_sweep,
    output hrf_pkg::t_pair     o_head,
    output logic               o_head_valid,
    input  wire logic          i_pop
);
    import hrf_pkg::*;

    localparam logic [1:0] Q_FULL = 2'd2;

    logic signed [31:0] r_prev_r;
    logic signed [31:0] r_prev_u;
    logic signed [31:0] r_prev_p;
    logic               r_have;
    logic               r_clr;
    t_pair              r_q [2];
    logic               r_wp;
    logic               r_rp;
    logic [1:0]         r_cnt;

    logic  accept;
    logic  push;
    t_pair entry;

    assign o_ready      = r_cnt != Q_FULL;
    assign accept       = i_valid && o_ready;
    assign push         = accept && r_have && !i_sweep;
    assign o_head       = r_q[r_rp];
    assign o_head_valid = r_cnt != 2'd0;

    always_comb begin
        entry.l_r = r_prev_r;
        entry.l_u = r_prev_u;
        entry.l_p = r_prev_p;
        entry.r_r = i_data[31:0];
        entry.r_u = i_data[63:32];
        entry.r_p = i_data[95:64];
        entry.clr = r_clr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_have <= 1'b0;
            r_clr  <= 1'b1;
            r_wp   <= 1'b0;
            r_rp   <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            if (accept) begin
                r_have <= 1'b1;
                r_clr  <= !push;
            end
            if (push) begin
                r_wp <= !r_wp;
            end
            if (i_pop) begin
                r_rp <= !r_rp;
            end
            r_cnt <= r_cnt + 2'(push) - 2'(i_pop);
        end
        if (accept) begin
            r_prev_r <= i_data[31:0];
            r_prev_u <= i_data[63:32];
            r_prev_p <= i_data[95:64];
        end
        if (push) begin
            r_q[r_wp] <= entry;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/hrf_back.sv
`default_nettype none

module hrf_back #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire hrf_pkg::t_pair i_pair,
    input  wire logic           i_pair_valid,
    output logic                o_pop,
    output logic                o_m_tvalid,
    input  wire logic           i_m_tready,
    output logic [127:0]        o_m_tdata,
    output logic [3:0]          o_m_tuser
);
    import hrf_pkg::*;

    localparam logic signed [31:0] K_GAMMA = 32'(((64'd14 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic signed [31:0] K_SHOCK = 32'(((64'd12 << FRAC_BITS) + 64'd7) / 64'd14);
    localparam logic signed [31:0] K_INV   = 32'((64'd5 << FRAC_BITS) / 64'd2);
    localparam logic signed [31:0] K_HALF  = 32'(64'd1 << (FRAC_BITS - 1));
    localparam logic signed [31:0] K_ONE   = 32'(64'd1 << FRAC_BITS);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_FETCH = 4'b0010,
        S_EXEC  = 4'b0100,
        S_WAIT  = 4'b1000
    } t_state;

    t_state             r_state, n_state;
    logic [PC_W-1:0]    r_pc, n_pc;
    logic [1:0]         r_region, n_region;
    logic               r_zflag, n_zflag;
    logic signed [31:0] r_smax, n_smax;
    logic signed [31:0] r_f0;
    logic signed [31:0] r_f1;

    t_instr             ins;
    logic signed [31:0] ra;
    logic signed [31:0] rb;
    logic               we;
    logic signed [31:0] wdata;
    logic signed [31:0] alu;
    logic signed [31:0] ld_val;
    logic signed [63:0] prod;
    logic signed [63:0] psh;
    logic signed [31:0] qmul;
    logic               it_start;
    logic               it_done;
    logic signed [31:0] it_res;
    logic               out_load;
    logic [1:0]         status;

    assign ins = prog(r_pc);

    hrf_ram #(.WIDTH(32), .DEPTH(NREG)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (ins.dst),
        .i_wdata (wdata),
        .i_raddr (ins.a),
        .o_rdata (ra)
    );

    hrf_ram #(.WIDTH(32), .DEPTH(NREG)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (ins.dst),
        .i_wdata (wdata),
        .i_raddr (ins.b),
        .o_rdata (rb)
    );

    hrf_iter #(.FRAC_BITS(FRAC_BITS)) u_iter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (it_start),
        .i_sqrt  (ins.op == OP_SQRT),
        .i_a     (ra),
        .i_b     (rb),
        .o_done  (it_done),
        .o_res   (it_res)
    );

    assign prod = 64'(ra) * 64'(rb);
    assign psh  = prod >>> FRAC_BITS;
    assign qmul = (psh[63:31] != {33{psh[63]}}) ? (psh[63] ? S32_MIN : S32_MAX) : psh[31:0];

    always_comb begin
        unique case (ins.a)
            R_RL:    ld_val = i_pair.l_r;
            R_UL:    ld_val = i_pair.l_u;
            R_PL:    ld_val = i_pair.l_p;
            R_RR:    ld_val = i_pair.r_r;
            R_UR:    ld_val = i_pair.r_u;
            R_PR:    ld_val = i_pair.r_p;
            R_KG:    ld_val = K_GAMMA;
            R_KS:    ld_val = K_SHOCK;
            R_KI:    ld_val = K_INV;
            R_KH:    ld_val = K_HALF;
            R_K1:    ld_val = K_ONE;
            default: ld_val = '0;
        endcase
    end

    always_comb begin
        unique case (ins.op)
            OP_LD:   alu = ld_val;
            OP_MOV:  alu = ra;
            OP_ADD:  alu = q_add(ra, rb);
            OP_SUB:  alu = q_sub(ra, rb);
            OP_MUL:  alu = qmul;
            OP_AVG:  alu = q_avg(ra, rb);
            OP_ABS:  alu = q_abs(ra);
            OP_MAX0: alu = ra[31] ? '0 : ra;
            OP_PICK: alu = K_ONE;
            OP_DIV:  alu = ra[31] ? S32_MIN : S32_MAX;
            default: alu = '0;
        endcase
    end

    assign status = (i_pair.l_p[31] || i_pair.r_p[31]) ? ST_NEGP :
                    (r_zflag ? ST_ZDEN : ST_OK);

    always_comb begin
        n_state  = r_state;
        n_pc     = r_pc;
        n_region = r_region;
        n_zflag  = r_zflag;
        n_smax   = r_smax;
        we       = 1'b0;
        wdata    = alu;
        it_start = 1'b0;
        o_pop    = 1'b0;
        out_load = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_pair_valid) begin
                    n_pc    = '0;
                    n_state = S_FETCH;
                    if (i_pair.clr) begin
                        n_smax = '0;
                    end
                end
            end
            S_FETCH: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_FETCH;
                n_pc    = r_pc + PC_W'(1);
                unique case (ins.op)
                    OP_LD, OP_MOV, OP_ADD, OP_SUB, OP_MUL, OP_AVG, OP_ABS,
                    OP_MAX0: begin
                        we = 1'b1;
                    end
                    OP_PICK: begin
                        we = ra <= rb;
                    end
                    OP_DIV: begin
                        if (rb == '0) begin
                            we = 1'b1;
                        end else begin
                            it_start = 1'b1;
                            n_state  = S_WAIT;
                            n_pc     = r_pc;
                        end
                    end
                    OP_SQRT: begin
                        if (ra <= 0) begin
                            we = 1'b1;
                        end else begin
                            it_start = 1'b1;
                            n_state  = S_WAIT;
                            n_pc     = r_pc;
                        end
                    end
                    OP_SMAX: begin
                        if (ra > r_smax) begin
                            n_smax = ra;
                        end
                    end
                    OP_ZCHK: begin
                        n_zflag = ra == '0;
                    end
                    OP_REG: begin
                        n_region = ins.a[1:0];
                    end
                    OP_BGEZ: begin
                        if (!ra[31]) begin
                            n_pc = ins.tgt;
                        end
                    end
                    OP_JMP: begin
                        n_pc = ins.tgt;
                    end
                    OP_BNS: begin
                        if (r_region == RG_LEFT || r_region == RG_RIGHT) begin
                            n_pc = ins.tgt;
                        end
                    end
                    OP_OUTA: begin
                    end
                    OP_OUTB: begin
                        if (!o_m_tvalid || i_m_tready) begin
                            out_load = 1'b1;
                            o_pop    = 1'b1;
                            n_state  = S_IDLE;
                        end else begin
                            n_state = S_EXEC;
                            n_pc    = r_pc;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            S_WAIT: begin
                if (it_done) begin
                    we      = 1'b1;
                    wdata   = it_res;
                    n_pc    = r_pc + PC_W'(1);
                    n_state = S_FETCH;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_pc       <= '0;
            r_region   <= RG_LEFT;
            r_zflag    <= 1'b0;
            r_smax     <= '0;
            o_m_tvalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_pc     <= n_pc;
            r_region <= n_region;
            r_zflag  <= n_zflag;
            r_smax   <= n_smax;
            if (out_load) begin
                o_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
        end
        if (r_state == S_EXEC && ins.op == OP_OUTA) begin
            r_f0 <= ra;
            r_f1 <= rb;
        end
        if (out_load) begin
            o_m_tdata <= {1'b0, r_smax[30:0], ra, r_f1, r_f0};
            o_m_tuser <= {status, r_region};
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/hllc_riemann_flux.sv
// Channel  Direction  Word
// s        in         tdata: density, velocity, pressure; tuser: sweep_start
// m        out        tdata: flux_mass, flux_momentum, flux_energy, max_speed, pad;
//                     tuser: region, status
// The front takes one cell per cycle while its two-entry pair queue has room.
// Each pair runs through a microcoded sequencer: 81 to 104 steps, each a fetch and an execute,
// plus five or eight divides and four square roots that wait on the iterative unit (a zero
// divisor or a non-positive radicand skips it), and a pass through the idle state per pair.
// Reset is synchronous and clears the stored cell, the queue and the speed maximum.
// A stalled result holds in the output register; the sequencer waits at its last step.
`default_nettype none

module hllc_riemann_flux #(
    parameter int FRAC_BITS = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_tvalid,
    output logic              o_s_tready,
    input  wire logic [95:0]  i_s_tdata,   // density, velocity, pressure
    input  wire logic [0:0]   i_s_tuser,   // sweep_start
    output logic              o_m_tvalid,
    input  wire logic         i_m_tready,
    output logic [127:0]      o_m_tdata,   // flux_mass, flux_momentum, flux_energy, max_speed
    output logic [3:0]        o_m_tuser    // region, status
);
    import hrf_pkg::*;

    t_pair head;
    logic  head_valid;
    logic  pop;

    hrf_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .o_ready      (o_s_tready),
        .i_data       (i_s_tdata),
        .i_sweep      (i_s_tuser[0]),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop)
    );

    hrf_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pair       (head),
        .i_pair_valid (head_valid),
        .o_pop        (pop),
        .o_m_tvalid   (o_m_tvalid),
        .i_m_tready   (i_m_tready),
        .o_m_tdata    (o_m_tdata),
        .o_m_tuser    (o_m_tuser)
    );

endmodule

`default_nettype wire
